// ===== sv/pls_pkg.sv =====
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and codes for the positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

   localparam int POS_BITS   = 4;
   localparam int COUNT_BITS = 5;
   localparam int DATA_BITS  = 64;

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_INSERT     = 3'd2,
      CMD_REMOVE     = 3'd3,
      CMD_POP_FRONT  = 3'd4,
      CMD_POP_BACK   = 3'd5,
      CMD_READ       = 3'd6,
      CMD_CLEAR      = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // the operation that every cell carries out
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2
   } cell_op_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [DATA_BITS-1:0]   value;
      logic [POS_BITS-1:0]    position;
   } req_type;

   typedef struct packed {
      logic [DATA_BITS-1:0]   data;
      logic [COUNT_BITS-1:0]  count;
      logic                   empty_res;
      status_type             status;
   } rsp_type;

endpackage

// ===== sv/positional_list_store.sv =====
// ----------------------------------------------------------------------------
// positional_list_store
// Bounded ordered list of words kept in a row of shifting cells.
// ----------------------------------------------------------------------------
//  channel   ports                      handshake
//  command   start, busy, req_data      taken when start & !busy
//  result    rsp_valid, rsp_data        one cycle strobe, no backpressure
//
// One command per cycle; busy stays low. The result appears the cycle after
// the command is taken. All cells load, shift or hold in parallel, so
// inserts and removes cost the same as reads. Reset empties the list at once.
// The result side cannot stall.
// ----------------------------------------------------------------------------
module positional_list_store #(
   parameter int CAPACITY  = 16,
   parameter int WORD_BITS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pls_pkg::req_type  req_data,
   output logic              rsp_valid,
   output pls_pkg::rsp_type  rsp_data
);
   import pls_pkg::*;

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int IW   = $clog2(CAPACITY);
   localparam int CMPW = (CW > POS_BITS) ? CW : POS_BITS;

   logic [CW-1:0]        n_ff;
   logic [CW-1:0]        n_in;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;

   logic                 accept;
   logic                 full;
   logic                 empty;
   logic [CMPW-1:0]      pos_c;
   logic [CMPW-1:0]      n_c;
   cell_op_type          op;
   logic [CW-1:0]        at;
   status_type           status;
   logic                 take_data;
   logic [WORD_BITS-1:0] new_word;
   logic [WORD_BITS-1:0] rd_word;

   logic [WORD_BITS-1:0] cell_q     [CAPACITY];
   logic [WORD_BITS-1:0] left_word  [CAPACITY];
   logic [WORD_BITS-1:0] right_word [CAPACITY];

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign full     = (n_ff == CW'(CAPACITY));
   assign empty    = (n_ff == '0);
   assign pos_c    = CMPW'(req_data.position);
   assign n_c      = CMPW'(n_ff);
   assign new_word = req_data.value[WORD_BITS-1:0];
   assign rd_word  = cell_q[at[IW-1:0]];

   always_comb begin
      op        = OP_HOLD;
      at        = '0;
      n_in      = n_ff;
      status    = ST_OK;
      take_data = 1'b0;
      unique case (req_data.cmd) inside
         CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               op   = OP_INSERT;
               n_in = n_ff + CW'(1);
               if (req_data.cmd == CMD_PUSH_FRONT) begin
                  at = '0;
               end else if (req_data.cmd == CMD_PUSH_BACK || pos_c >= n_c) begin
                  at = n_ff;
               end else begin
                  at = CW'(pos_c);
               end
            end
         end
         CMD_REMOVE: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               op        = OP_REMOVE;
               n_in      = n_ff - CW'(1);
               take_data = 1'b1;
               at        = (pos_c >= n_c - CMPW'(1)) ? n_ff - CW'(1) : CW'(pos_c);
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               op        = OP_REMOVE;
               n_in      = n_ff - CW'(1);
               take_data = 1'b1;
               at        = (req_data.cmd == CMD_POP_FRONT) ? '0 : n_ff - CW'(1);
            end
         end
         CMD_READ: begin
            if (pos_c < n_c) begin
               take_data = 1'b1;
               at        = CW'(pos_c);
            end else begin
               status = ST_RANGE;
            end
         end
         CMD_CLEAR: begin
            n_in = '0;
         end
         default: begin
            n_in = n_ff;
         end
      endcase
      if (!accept) begin
         op   = OP_HOLD;
         n_in = n_ff;
      end
   end

   always_comb begin
      rsp_in.data      = take_data ? DATA_BITS'(rd_word) : '0;
      rsp_in.count     = COUNT_BITS'(n_in);
      rsp_in.empty_res = (n_in == '0);
      rsp_in.status    = status;
   end

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         if (gi == 0) begin : g_first
            assign left_word[gi] = '0;
         end else begin : g_left
            assign left_word[gi] = cell_q[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_last
            assign right_word[gi] = '0;
         end else begin : g_right
            assign right_word[gi] = cell_q[gi+1];
         end
         pls_cell #(
            .WORD_BITS (WORD_BITS),
            .CW        (CW),
            .INDEX     (gi)
         ) u_cell (
            .clock      (clock),
            .op         (op),
            .at         (at),
            .fill       (n_ff),
            .new_word   (new_word),
            .left_word  (left_word[gi]),
            .right_word (right_word[gi]),
            .q          (cell_q[gi])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         n_ff         <= n_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      n_ff <= CW'(CAPACITY))
      else $error("fill count above capacity");

   a_one_result : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("taken command gave no result");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid)
      else $error("result without a command");

   a_full_drop : assert property (@(posedge clock) disable iff (reset)
      (accept && full && (req_data.cmd == CMD_PUSH_FRONT
         || req_data.cmd == CMD_PUSH_BACK || req_data.cmd == CMD_INSERT))
      |=> (n_ff == $past(n_ff) && rsp_data.status == ST_FULL))
      else $error("push into full list changed the count");

   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> rsp_data.data == '0)
      else $error("failed command returned data");

endmodule

// ===== sv/pls_cell.sv =====
// ----------------------------------------------------------------------------
// pls_cell
// One list slot: holds, loads the new word, or shifts from a neighbor.
// ----------------------------------------------------------------------------
module pls_cell #(
   parameter int WORD_BITS = 64,
   parameter int CW        = 5,
   parameter int INDEX     = 0
) (
   input  logic                  clock,
   input  pls_pkg::cell_op_type  op,
   input  logic [CW-1:0]         at,
   input  logic [CW-1:0]         fill,
   input  logic [WORD_BITS-1:0]  new_word,
   input  logic [WORD_BITS-1:0]  left_word,
   input  logic [WORD_BITS-1:0]  right_word,
   output logic [WORD_BITS-1:0]  q
);
   import pls_pkg::*;

   localparam logic [CW-1:0] MY_IDX = CW'(INDEX);

   logic [WORD_BITS-1:0] q_ff;
   logic [WORD_BITS-1:0] q_in;

   always_comb begin
      q_in = q_ff;
      unique case (op)
         OP_INSERT: begin
            if (MY_IDX == at) begin
               q_in = new_word;
            end else if (MY_IDX > at && MY_IDX <= fill) begin
               q_in = left_word;
            end
         end
         OP_REMOVE: begin
            if (MY_IDX >= at && (MY_IDX + CW'(1)) < fill) begin
               q_in = right_word;
            end
         end
         default: q_in = q_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign q = q_ff;

endmodule

// ===== dv/tb_positional_list_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_store
// Self-checking bench for the positional list store.
// A short table of directed commands covers empty, full, range and clear
// cases, then biased random phases grow, drain and churn the list. Each
// result is checked against its typed table row or a behavioral list copy.
// ----------------------------------------------------------------------------
module tb_positional_list_store;
   import pls_pkg::*;

   localparam int LIST_DEPTH = 16;
   localparam int STALL_LIMIT = 1000;
   localparam int PHASES = 10;
   localparam int PHASE_WORDS = 100;

   typedef struct {
      cmd_type             cmd;
      logic [63:0]         value;
      logic [3:0]          position;
      int                  reps;
      bit                  typed;
      rsp_type             want;
   } dir_row_type;

   typedef struct {
      bit      typed;
      rsp_type want;
   } pend_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   logic [63:0] list_words [LIST_DEPTH];
   int unsigned list_fill;
   pend_type    pend_q [$];
   rsp_type     want_q [$];
   dir_row_type dir_rows [$];
   int          err_count;
   int          stall_cycles;

   positional_list_store uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type list_apply(input req_type w);
      rsp_type     r;
      int unsigned at;
      int          i;
      r = '0;
      r.status = ST_OK;
      case (w.cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
            if (list_fill >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               if (w.cmd == CMD_PUSH_FRONT) at = 0;
               else if (w.cmd == CMD_PUSH_BACK || w.position >= list_fill) at = list_fill;
               else at = w.position;
               for (i = list_fill; i > at; i--) list_words[i] = list_words[i-1];
               list_words[at] = w.value;
               list_fill++;
            end
         end
         CMD_REMOVE, CMD_POP_FRONT, CMD_POP_BACK: begin
            if (list_fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               if (w.cmd == CMD_POP_FRONT) at = 0;
               else if (w.cmd == CMD_POP_BACK || w.position >= list_fill - 1) at = list_fill - 1;
               else at = w.position;
               r.data = list_words[at];
               for (i = at; i + 1 < list_fill; i++) list_words[i] = list_words[i+1];
               list_fill--;
            end
         end
         CMD_READ: begin
            if (w.position < list_fill) r.data = list_words[w.position];
            else r.status = ST_RANGE;
         end
         default: begin
            list_fill = 0;
         end
      endcase
      r.count = 5'(list_fill);
      r.empty_res = (list_fill == 0);
      return r;
   endfunction

   function automatic void add_row(input cmd_type c, input logic [63:0] v,
                                   input logic [3:0] p, input int n, input bit typed,
                                   input logic [63:0] d, input logic [4:0] cnt,
                                   input logic e, input status_type s);
      dir_row_type row;
      row.cmd = c;
      row.value = v;
      row.position = p;
      row.reps = n;
      row.typed = typed;
      row.want.data = d;
      row.want.count = cnt;
      row.want.empty_res = e;
      row.want.status = s;
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   function automatic cmd_type pick_cmd(input int kind);
      int roll;
      int grow;
      roll = $urandom_range(99);
      grow = (kind == 0) ? 70 : (kind == 1) ? 15 : 40;
      if (roll < 2) return CMD_CLEAR;
      if (roll < 2 + grow) return cmd_type'(3'($urandom_range(2)));
      if (roll < 17 + grow) return CMD_READ;
      return cmd_type'(3'($urandom_range(5, 3)));
   endfunction

   // hold one word on the command port until it is taken
   task automatic send_word(input req_type w, input bit typed, input rsp_type want,
                            input bit may_idle);
      pend_type p;
      while (may_idle && $urandom_range(99) < 21) begin
         start <= 1'b0;
         @(posedge clock);
      end
      p.typed = typed;
      p.want = want;
      pend_q.insert(pend_q.size(), p);
      start <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_drained();
      while (pend_q.size() != 0 || want_q.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_type  pr;
      rsp_type  exp_w;
      pend_type p;
      bit       moved;
      if (!reset) begin
         moved = 1'b0;
         if (start && !busy) begin
            moved = 1'b1;
            p = pend_q[0];
            pend_q.delete(0);
            pr = list_apply(req_data);
            want_q.insert(want_q.size(), p.typed ? p.want : pr);
         end
         if (rsp_valid) begin
            moved = 1'b1;
            if (want_q.size() == 0) begin
               $error("unexpected result word: %h", rsp_data);
               err_count++;
            end else begin
               exp_w = want_q[0];
               want_q.delete(0);
               if (rsp_data.data !== exp_w.data) begin
                  $error("data: expected %h, got %h", exp_w.data, rsp_data.data);
                  err_count++;
               end
               if (rsp_data.count !== exp_w.count) begin
                  $error("count: expected %0d, got %0d", exp_w.count, rsp_data.count);
                  err_count++;
               end
               if (rsp_data.empty_res !== exp_w.empty_res) begin
                  $error("empty_res: expected %b, got %b", exp_w.empty_res,
                         rsp_data.empty_res);
                  err_count++;
               end
               if (rsp_data.status !== exp_w.status) begin
                  $error("status: expected %0d, got %0d", exp_w.status, rsp_data.status);
                  err_count++;
               end
            end
         end
         stall_cycles = moved ? 0 : stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      req_type     w;
      rsp_type     none;
      int          r;
      int          k;
      int          ph;
      int          kind;
      logic [63:0] v;
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      list_fill = 0;
      err_count = 0;
      stall_cycles = 0;
      none = '0;

      add_row(CMD_POP_FRONT, '0, 4'd0, 1, 1, '0, 5'd0, 1'b1, ST_EMPTY);
      add_row(CMD_POP_BACK, '0, 4'd0, 1, 1, '0, 5'd0, 1'b1, ST_EMPTY);
      add_row(CMD_REMOVE, '0, 4'd15, 1, 1, '0, 5'd0, 1'b1, ST_EMPTY);
      add_row(CMD_READ, '0, 4'd0, 1, 1, '0, 5'd0, 1'b1, ST_RANGE);
      add_row(CMD_PUSH_FRONT, '1, 4'd0, 1, 1, '0, 5'd1, 1'b0, ST_OK);
      add_row(CMD_READ, '0, 4'd0, 1, 1, '1, 5'd1, 1'b0, ST_OK);
      add_row(CMD_PUSH_BACK, '0, 4'd0, 1, 1, '0, 5'd2, 1'b0, ST_OK);
      add_row(CMD_INSERT, 64'hA5A5_5A5A_C3C3_3C3C, 4'd15, 1, 1, '0, 5'd3, 1'b0, ST_OK);
      add_row(CMD_INSERT, 64'h0123_4567_89AB_CDEF, 4'd0, 1, 0, '0, '0, 1'b0, ST_OK);
      add_row(CMD_INSERT, 64'hFEDC_BA98_7654_3210, 4'd2, 1, 0, '0, '0, 1'b0, ST_OK);
      add_row(CMD_READ, '0, 4'd15, 1, 1, '0, 5'd5, 1'b0, ST_RANGE);
      add_row(CMD_REMOVE, '0, 4'd15, 1, 0, '0, '0, 1'b0, ST_OK);
      add_row(CMD_REMOVE, '0, 4'd1, 1, 0, '0, '0, 1'b0, ST_OK);
      add_row(CMD_POP_BACK, '0, 4'd0, 1, 0, '0, '0, 1'b0, ST_OK);
      add_row(CMD_POP_FRONT, '0, 4'd0, 1, 0, '0, '0, 1'b0, ST_OK);
      add_row(CMD_CLEAR, '0, 4'd0, 1, 1, '0, 5'd0, 1'b1, ST_OK);
      add_row(CMD_PUSH_BACK, 64'h1111_2222_3333_4400, 4'd0, 16, 0, '0, '0, 1'b0, ST_OK);
      add_row(CMD_PUSH_FRONT, '1, 4'd0, 1, 1, '0, 5'd16, 1'b0, ST_FULL);
      add_row(CMD_PUSH_BACK, '1, 4'd0, 1, 1, '0, 5'd16, 1'b0, ST_FULL);
      add_row(CMD_INSERT, '1, 4'd5, 1, 1, '0, 5'd16, 1'b0, ST_FULL);
      add_row(CMD_READ, '0, 4'd15, 1, 0, '0, '0, 1'b0, ST_OK);
      add_row(CMD_REMOVE, '0, 4'd0, 1, 0, '0, '0, 1'b0, ST_OK);
      add_row(CMD_INSERT, 64'h8000_0000_0000_0001, 4'd0, 1, 0, '0, '0, 1'b0, ST_OK);
      add_row(CMD_CLEAR, '0, 4'd0, 1, 1, '0, 5'd0, 1'b1, ST_OK);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         for (r = 0; r < dir_rows[i].reps; r++) begin
            w.cmd = dir_rows[i].cmd;
            w.value = dir_rows[i].value ^ 64'(r);
            w.position = dir_rows[i].position;
            send_word(w, dir_rows[i].typed, dir_rows[i].want, 1'b1);
         end
      end

      for (ph = 0; ph < PHASES; ph++) begin
         kind = ph % 3;
         if (ph == 5) begin
            start <= 1'b0;
            @(posedge clock);
            wait_drained();
         end
         for (k = 0; k < PHASE_WORDS; k++) begin
            v = {$urandom, $urandom};
            case ($urandom_range(9))
               0: v = '0;
               1: v = '1;
               default: ;
            endcase
            w.cmd = pick_cmd(kind);
            w.value = v;
            if ($urandom_range(1)) w.position = 4'($urandom_range(15));
            else w.position = 4'($urandom_range(list_fill > 15 ? 15 : list_fill));
            send_word(w, 1'b0, none, ph != 3);
         end
      end

      start <= 1'b0;
      wait_drained();
      repeat (4) @(posedge clock);
      if (err_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/pls_pkg.sv
sv/pls_cell.sv
sv/positional_list_store.sv
dv/tb_positional_list_store.sv
